/* design/tape_image_block_splitter_defines.svh */
// Assertion macros shared by the tape image block splitter RTL.
`ifndef TAPE_IMAGE_BLOCK_SPLITTER_DEFINES_SVH
`define TAPE_IMAGE_BLOCK_SPLITTER_DEFINES_SVH

// Implication checked in the same cycle.
`define TIBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define TIBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tibs_pkg.sv */
// Package: types, block ids and the block layout table for the tape image splitter.
`timescale 1ns / 1ps
package tibs_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int INDEX_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;

   localparam logic [4:0] TZX_HEADER_LEN = 5'd10;

   // TZX block ids with a nonzero layout
   localparam logic [7:0] ID_STD_SPEED   = 8'h10;
   localparam logic [7:0] ID_TURBO       = 8'h11;
   localparam logic [7:0] ID_PURE_TONE   = 8'h12;
   localparam logic [7:0] ID_PULSES      = 8'h13;
   localparam logic [7:0] ID_PURE_DATA   = 8'h14;
   localparam logic [7:0] ID_DIRECT_REC  = 8'h15;
   localparam logic [7:0] ID_GENERALIZED = 8'h19;
   localparam logic [7:0] ID_PAUSE       = 8'h20;
   localparam logic [7:0] ID_GROUP_START = 8'h21;
   localparam logic [7:0] ID_LOOP_START  = 8'h24;
   localparam logic [7:0] ID_STOP_48K    = 8'h2A;
   localparam logic [7:0] ID_SET_LEVEL   = 8'h2B;
   localparam logic [7:0] ID_TEXT        = 8'h30;
   localparam logic [7:0] ID_MESSAGE     = 8'h31;
   localparam logic [7:0] ID_ARCHIVE     = 8'h32;
   localparam logic [7:0] ID_HARDWARE    = 8'h33;
   localparam logic [7:0] ID_CUSTOM      = 8'h35;
   localparam logic [7:0] ID_GLUE        = 8'h5A;

   typedef enum logic [1:0] {
      PH_FILEHDR = 2'd0,
      PH_START   = 2'd1,
      PH_HEADER  = 2'd2,
      PH_BODY    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_COMPLETE   = 2'd0,
      ST_BODY_CUT   = 2'd1,
      ST_HEADER_CUT = 2'd2
   } status_type;

   // header bytes after the id, length field offset, length field bytes, scale
   typedef struct packed {
      logic [4:0] hdr;
      logic [4:0] off;
      logic [2:0] cnt;
      logic [1:0] mult;
   } layout_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] size;
      logic [31:0] offset;
      logic [7:0]  kind;
      logic [15:0] number;
   } result_type;

   function automatic layout_type mk(input logic [4:0] h, input logic [4:0] o,
                                     input logic [2:0] c, input logic [1:0] m);
      layout_type l;
      l.hdr  = h;
      l.off  = o;
      l.cnt  = c;
      l.mult = m;
      return l;
   endfunction

   function automatic layout_type layout_of(input logic [7:0] kind, input logic tap);
      layout_type l;
      if (tap) begin
         l = mk(5'd2, 5'd0, 3'd2, 2'd1);
      end else begin
         case (kind)
            ID_STD_SPEED:   l = mk(5'd4,  5'd2,  3'd2, 2'd1);
            ID_TURBO:       l = mk(5'd18, 5'd15, 3'd3, 2'd1);
            ID_PURE_TONE:   l = mk(5'd4,  5'd0,  3'd0, 2'd0);
            ID_PULSES:      l = mk(5'd1,  5'd0,  3'd1, 2'd2);
            ID_PURE_DATA:   l = mk(5'd10, 5'd7,  3'd3, 2'd1);
            ID_DIRECT_REC:  l = mk(5'd8,  5'd5,  3'd3, 2'd1);
            ID_GENERALIZED: l = mk(5'd4,  5'd0,  3'd4, 2'd1);
            ID_PAUSE:       l = mk(5'd2,  5'd0,  3'd0, 2'd0);
            ID_GROUP_START: l = mk(5'd1,  5'd0,  3'd1, 2'd1);
            ID_LOOP_START:  l = mk(5'd2,  5'd0,  3'd0, 2'd0);
            ID_STOP_48K:    l = mk(5'd4,  5'd0,  3'd0, 2'd0);
            ID_SET_LEVEL:   l = mk(5'd5,  5'd0,  3'd0, 2'd0);
            ID_TEXT:        l = mk(5'd1,  5'd0,  3'd1, 2'd1);
            ID_MESSAGE:     l = mk(5'd2,  5'd1,  3'd1, 2'd1);
            ID_ARCHIVE:     l = mk(5'd2,  5'd0,  3'd2, 2'd1);
            ID_HARDWARE:    l = mk(5'd1,  5'd0,  3'd1, 2'd3);
            ID_CUSTOM:      l = mk(5'd20, 5'd16, 3'd4, 2'd1);
            ID_GLUE:        l = mk(5'd9,  5'd0,  3'd0, 2'd0);
            default:        l = mk(5'd0,  5'd0,  3'd0, 2'd0);
         endcase
      end
      return l;
   endfunction

endpackage

/* design/tibs_parser.sv */
// Front end: walks the image byte by byte and builds one result per finished or cut block.
`timescale 1ns / 1ps
module tibs_parser import tibs_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int INDEX_BITS    = INDEX_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       in_accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       out_push,
   output result_type out_result
);

   localparam int SeenW = (POSITION_BITS > 32) ? POSITION_BITS : 33;

   logic                     format_ff, format_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [INDEX_BITS-1:0]    count_ff, count_in;
   logic [7:0]               kind_ff, kind_in;
   phase_type                phase_ff, phase_in, phase_step;
   logic [4:0]               hseen_ff, hseen_in;
   logic [31:0]              len_ff, len_in;
   logic [33:0]              left_ff, left_in;
   logic                     tap_ff, tap_in;
   logic [31:0]              total_ff, total_in;

   // datapath
   logic                     fmt_tap, begin_blk, consume, in_hdr, capture;
   logic [7:0]               kind_e;
   logic                     tap_e;
   logic [4:0]               hs_e, hs_n, hs_fh, cap_idx;
   logic [31:0]              len_e, len_n;
   layout_type               lay;
   logic [33:0]              body, total_full, body_dec;
   logic [31:0]              total_sat;
   logic                     finish, body_zero, done;
   logic [POSITION_BITS-1:0] start_new, seen;
   logic [SeenW-1:0]         seen_wide;
   logic [31:0]              seen_sat;

   always_comb begin
      fmt_tap   = !format_ff;
      begin_blk = (phase_ff == PH_START) || ((phase_ff == PH_FILEHDR) && fmt_tap);
      consume   = (phase_ff == PH_HEADER) || (begin_blk && fmt_tap);
      in_hdr    = (phase_ff == PH_HEADER) || begin_blk;
      kind_e    = begin_blk ? (fmt_tap ? ID_STD_SPEED : in_byte) : kind_ff;
      tap_e     = begin_blk ? fmt_tap : tap_ff;
      hs_e      = begin_blk ? 5'd0 : hseen_ff;
      len_e     = begin_blk ? 32'd0 : len_ff;
      start_new = begin_blk ? pos_ff : start_ff;
      lay       = layout_of(kind_e, tap_e);

      capture = consume && (hs_e >= lay.off) &&
                ({1'b0, hs_e} < (6'(lay.off) + 6'(lay.cnt)));
      cap_idx = hs_e - lay.off;
      len_n   = capture ? (len_e | (32'(in_byte) << {cap_idx[1:0], 3'b000})) : len_e;
      hs_n    = consume ? 5'(hs_e + 5'd1) : hs_e;
      finish  = in_hdr && (hs_n >= lay.hdr);

      case (lay.mult)
         2'd1:    body = 34'(len_n);
         2'd2:    body = {1'b0, len_n, 1'b0};
         2'd3:    body = 34'(len_n) + {1'b0, len_n, 1'b0};
         default: body = 34'd0;
      endcase
      body_zero  = (len_n == 32'd0) || (lay.mult == 2'd0);
      total_full = body + 34'(lay.hdr) + (tap_e ? 34'd0 : 34'd1);
      total_sat  = (total_full[33:32] != 2'b00) ? 32'hFFFF_FFFF : total_full[31:0];

      body_dec = (left_ff != 34'd0) ? (left_ff - 34'd1) : 34'd0;
      done     = (finish && body_zero) || ((phase_ff == PH_BODY) && (body_dec == 34'd0));

      hs_fh = 5'(hseen_ff + 5'd1);

      seen      = pos_ff + POSITION_BITS'(1) - start_new;
      seen_wide = SeenW'(seen);
      seen_sat  = (seen_wide[SeenW-1:32] != '0) ? 32'hFFFF_FFFF : seen_wide[31:0];
   end

   // next state
   always_comb begin
      case (phase_ff)
         PH_FILEHDR: begin
            if (format_ff) begin
               phase_step = (hs_fh >= TZX_HEADER_LEN) ? PH_START : PH_FILEHDR;
            end else begin
               phase_step = finish ? (body_zero ? PH_START : PH_BODY) : PH_HEADER;
            end
         end
         PH_START, PH_HEADER: begin
            phase_step = finish ? (body_zero ? PH_START : PH_BODY) : PH_HEADER;
         end
         PH_BODY: begin
            phase_step = (body_dec == 34'd0) ? PH_START : PH_BODY;
         end
         default: phase_step = PH_FILEHDR;
      endcase
      phase_in = !in_accept ? phase_ff : (in_last ? PH_FILEHDR : phase_step);
   end

   // outputs
   always_comb begin
      out_push = in_accept &&
                 (done || (in_last && ((phase_step == PH_HEADER) || (phase_step == PH_BODY))));
      out_result.number = 16'(count_ff);
      out_result.kind   = kind_e;
      out_result.offset = 32'(start_new);
      if (done) begin
         out_result.size   = finish ? total_sat : total_ff;
         out_result.status = ST_COMPLETE;
      end else begin
         out_result.size   = seen_sat;
         out_result.status = (phase_step == PH_HEADER) ? ST_HEADER_CUT : ST_BODY_CUT;
      end
   end

   // remaining registers
   always_comb begin
      format_in = csr_wr_en ? csr_wr_data : format_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      kind_in   = kind_ff;
      hseen_in  = hseen_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      tap_in    = tap_ff;
      total_in  = total_ff;
      if (in_accept) begin
         if (in_last) begin
            pos_in   = '0;
            start_in = '0;
            count_in = '0;
            kind_in  = 8'd0;
            hseen_in = 5'd0;
            len_in   = 32'd0;
            left_in  = 34'd0;
            tap_in   = 1'b0;
            total_in = 32'd0;
         end else begin
            pos_in   = pos_ff + POSITION_BITS'(1);
            start_in = start_new;
            kind_in  = kind_e;
            tap_in   = tap_e;
            if (done) begin
               count_in = count_ff + INDEX_BITS'(1);
            end
            if (finish) begin
               total_in = total_sat;
            end
            if ((phase_ff == PH_FILEHDR) && format_ff) begin
               hseen_in = (hs_fh >= TZX_HEADER_LEN) ? 5'd0 : hs_fh;
            end else if (in_hdr) begin
               hseen_in = done ? 5'd0 : hs_n;
               len_in   = done ? 32'd0 : len_n;
               left_in  = (finish && !body_zero) ? body : 34'd0;
            end else begin
               hseen_in = done ? 5'd0 : hseen_ff;
               left_in  = body_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 1'b1;
         pos_ff    <= '0;
         start_ff  <= '0;
         count_ff  <= '0;
         kind_ff   <= 8'd0;
         phase_ff  <= PH_FILEHDR;
         hseen_ff  <= 5'd0;
         len_ff    <= 32'd0;
         left_ff   <= 34'd0;
         tap_ff    <= 1'b0;
         total_ff  <= 32'd0;
      end else begin
         format_ff <= format_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         count_ff  <= count_in;
         kind_ff   <= kind_in;
         phase_ff  <= phase_in;
         hseen_ff  <= hseen_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         tap_ff    <= tap_in;
         total_ff  <= total_in;
      end
   end

endmodule

/* design/tibs_result_queue.sv */
// Back end: small result queue whose head drives the result channel.
`timescale 1ns / 1ps
module tibs_result_queue import tibs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output result_type head_data
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   result_type          slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full       = (count_ff == CntW'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_data  = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/tape_image_block_splitter.sv */
// Top level of the tape image block splitter: parser front end and result queue.
// Usage:
//  - req channel: one image byte per request (req_tdata), req_tlast on the last byte.
//  - rsp channel: one result per finished block, or one status result when the
//    image stops inside a block (rsp_tuser = 1 cut in body, 2 cut in header).
//  - csr_wr_en/csr_wr_data: image format, 0 = TAP, 1 = TZX (reset value).
//    Write only while idle; it applies from the next file header byte or block start.
// Timing:
//  - Throughput: one request per cycle unless the queue is full.
//    Each byte only updates counters. Results are registered in the queue ahead of rsp.
//  - The parser finishes every request in the cycle it is accepted, so the result
//    queue depth (QUEUE_DEPTH) alone sets how long req keeps flowing under a stall.
// Reset: synchronous, active high. Parser returns to file header phase, counters
//    clear, queue empties, format goes to TZX. After req_tlast the parser state
//    also clears (format kept), so the next request starts a new image.
// Stall: while rsp_tready is low results collect in the queue; when it is full
//    req_tready drops until a result is taken.
`timescale 1ns / 1ps
`include "tape_image_block_splitter_defines.svh"
module tape_image_block_splitter import tibs_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int INDEX_BITS    = INDEX_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [15:0] block_number, [23:16] block_kind,
                                    // [55:24] block_offset, [87:56] block_size
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic       req_accept;
   logic       push;
   result_type push_data;
   logic       queue_full;
   result_type head;

   // a request is taken only when the queue can hold whatever it produces
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   tibs_parser #(
      .POSITION_BITS (POSITION_BITS),
      .INDEX_BITS    (INDEX_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_accept   (req_accept),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .out_push    (push),
      .out_result  (push_data)
   );

   tibs_result_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (head)
   );

   assign rsp_tdata = {head.size, head.offset, head.kind, head.number};
   assign rsp_tuser = head.status;

   // results only come from accepted requests, never into a full queue
   `TIBS_ASSERT_NOW(a_push_on_accept, clock, reset, push, req_accept, "result without accepted request")
   // a cut-block status only on the last byte of an image
   `TIBS_ASSERT_NOW(a_cut_needs_last, clock, reset, push && (push_data.status != ST_COMPLETE), req_tlast, "cut status without end of image")
   // a result pushed into an empty queue shows up on rsp next cycle
   `TIBS_ASSERT_NEXT(a_push_visible, clock, reset, push && !rsp_tvalid, rsp_tvalid, "pushed result not presented")

endmodule

/* bench/tape_image_block_splitter_tb.sv */
// Self-checking testbench for the tape image block splitter: TAP/TZX images in, block records out.
`timescale 1ns / 1ps
module tape_image_block_splitter_tb;
   import tibs_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 8;
   localparam int HOLD_CYCLES = 300;     // long receiver stall, queue is only 4 deep
   localparam int PHASE_BYTES = 600;

   // one image byte as offered on the request channel
   typedef struct {
      logic [7:0] data;
      logic       last;
   } tape_byte_type;

   // TZX block layout: header bytes after the id, length field offset/bytes, scale
   typedef struct {
      int hdr;
      int off;
      int cnt;
      int mult;
   } block_shape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // end_of_image
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;          // [15:0] number, [23:16] kind, [55:24] offset, [87:56] size
   logic [1:0]  rsp_tuser;          // [1:0] status

   tape_image_block_splitter dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   tape_byte_type bytes_to_send [$]; // requests waiting for the driver
   result_type  blocks_due [$];      // block records predicted, not yet seen
   logic [7:0]  image_bytes [$];     // image under construction
   int          errors = 0;
   int          cycle_count = 0;
   int          sent_in_phase = 0;
   int          send_idle_pct = 23;
   int          recv_idle_pct = 67;
   logic        hold_req = 1'b0;
   int          hold_left = 0;

   logic [7:0] known_ids [18] = '{ID_STD_SPEED, ID_TURBO, ID_PURE_TONE, ID_PULSES,
                                  ID_PURE_DATA, ID_DIRECT_REC, ID_GENERALIZED, ID_PAUSE,
                                  ID_GROUP_START, ID_LOOP_START, ID_STOP_48K, ID_SET_LEVEL,
                                  ID_TEXT, ID_MESSAGE, ID_ARCHIVE, ID_HARDWARE, ID_CUSTOM,
                                  ID_GLUE};

   // ------------------------------------------------------------------
   // Parser prediction: mirror of the block's counters, one byte at a time
   // ------------------------------------------------------------------
   logic        fmt_tzx;       // copy of the format register
   logic [31:0] img_pos;
   logic [31:0] blk_start;
   logic [15:0] blk_count;
   logic [7:0]  blk_kind;
   phase_type   blk_phase;
   logic [4:0]  hdr_count;
   logic [31:0] len_field;
   logic [33:0] body_rem;
   logic        blk_tap;       // mode latched when the block began
   logic [35:0] blk_total;

   function automatic block_shape_type shape_of(input logic [7:0] id, input logic tap);
      block_shape_type s;
      s = '{0, 0, 0, 0};
      if (tap) begin
         s = '{2, 0, 2, 1};
      end else begin
         case (id)
            ID_STD_SPEED:   s = '{4, 2, 2, 1};
            ID_TURBO:       s = '{18, 15, 3, 1};
            ID_PURE_TONE:   s = '{4, 0, 0, 0};
            ID_PULSES:      s = '{1, 0, 1, 2};
            ID_PURE_DATA:   s = '{10, 7, 3, 1};
            ID_DIRECT_REC:  s = '{8, 5, 3, 1};
            ID_GENERALIZED: s = '{4, 0, 4, 1};
            ID_PAUSE:       s = '{2, 0, 0, 0};
            ID_GROUP_START: s = '{1, 0, 1, 1};
            ID_LOOP_START:  s = '{2, 0, 0, 0};
            ID_STOP_48K:    s = '{4, 0, 0, 0};
            ID_SET_LEVEL:   s = '{5, 0, 0, 0};
            ID_TEXT:        s = '{1, 0, 1, 1};
            ID_MESSAGE:     s = '{2, 1, 1, 1};
            ID_ARCHIVE:     s = '{2, 0, 2, 1};
            ID_HARDWARE:    s = '{1, 0, 1, 3};
            ID_CUSTOM:      s = '{20, 16, 4, 1};  // 16-byte id string before the length
            ID_GLUE:        s = '{9, 0, 0, 0};
            default:        s = '{0, 0, 0, 0};    // unsupported id: one-byte block
         endcase
      end
      return s;
   endfunction

   task automatic clear_parser();
      img_pos   = '0;
      blk_start = '0;
      blk_count = '0;
      blk_kind  = '0;
      blk_phase = PH_FILEHDR;
      hdr_count = '0;
      len_field = '0;
      body_rem  = '0;
      blk_tap   = 1'b0;
      blk_total = '0;
   endtask

   // header done: the length decides whether a body follows
   task automatic end_header(output logic done);
      block_shape_type s;
      logic [35:0]  body;
      s = shape_of(blk_kind, blk_tap);
      body = 36'(len_field) * 36'(s.mult);
      blk_total = (blk_tap ? 36'd0 : 36'd1) + 36'(s.hdr) + body;
      done = 1'b0;
      if (body == 0) begin
         done = 1'b1;
      end else begin
         body_rem  = body[33:0];
         blk_phase = PH_BODY;
      end
   endtask

   task automatic take_header_byte(input logic [7:0] b, output logic done);
      block_shape_type s;
      int           h;
      s = shape_of(blk_kind, blk_tap);
      h = hdr_count;
      done = 1'b0;
      if (h >= s.off && h < s.off + s.cnt)
         len_field = len_field | (32'(b) << (8 * (h - s.off)));
      hdr_count = hdr_count + 5'd1;
      if (hdr_count >= s.hdr)
         end_header(done);
   endtask

   task automatic open_block(input logic [7:0] b, output logic done);
      block_shape_type s;
      blk_start = img_pos;
      blk_tap   = !fmt_tzx;
      hdr_count = '0;
      len_field = '0;
      body_rem  = '0;
      blk_phase = PH_HEADER;
      done = 1'b0;
      if (blk_tap) begin
         blk_kind = ID_STD_SPEED;   // TAP blocks report the standard speed id
         take_header_byte(b, done);
      end else begin
         blk_kind = b;
         s = shape_of(b, 1'b0);
         if (s.hdr == 0)
            end_header(done);
      end
   endtask

   task automatic parse_tape_byte(input logic [7:0] b, input logic last,
                                  output logic got, output result_type r);
      logic done;
      done = 1'b0;
      got  = 1'b0;
      r    = '0;
      case (blk_phase)
         PH_FILEHDR: begin
            if (fmt_tzx) begin
               // TZX file header is skipped unchecked
               hdr_count = hdr_count + 5'd1;
               if (hdr_count >= TZX_HEADER_LEN) begin
                  hdr_count = '0;
                  blk_phase = PH_START;
               end
            end else begin
               open_block(b, done);
            end
         end
         PH_START:  open_block(b, done);
         PH_HEADER: take_header_byte(b, done);
         default: begin
            if (body_rem != 0)
               body_rem = body_rem - 34'd1;
            if (body_rem == 0)
               done = 1'b1;
         end
      endcase

      if (done) begin
         r.number = blk_count;
         r.kind   = blk_kind;
         r.offset = blk_start;
         r.size   = (blk_total > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : blk_total[31:0];
         r.status = ST_COMPLETE;
         got = 1'b1;
         blk_count = blk_count + 16'd1;
         blk_phase = PH_START;
         hdr_count = '0;
         len_field = '0;
         body_rem  = '0;
      end else if (last && (blk_phase == PH_HEADER || blk_phase == PH_BODY)) begin
         // image cut inside a block: report what arrived of it
         r.number = blk_count;
         r.kind   = blk_kind;
         r.offset = blk_start;
         r.size   = img_pos + 32'd1 - blk_start;
         r.status = (blk_phase == PH_HEADER) ? ST_HEADER_CUT : ST_BODY_CUT;
         got = 1'b1;
      end

      if (last)
         clear_parser();
      else
         img_pos = img_pos + 32'd1;
   endtask

   // ------------------------------------------------------------------
   // Driver: offers queued requests, random gaps per send_idle_pct
   // ------------------------------------------------------------------
   always @(posedge clock) begin : driver
      tape_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = bytes_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.data;
            req_tlast  <= nxt.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus the long hold when one is running
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && !hold_req &&
                       ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Long-hold counter, kicked off by hold_req
   always @(posedge clock) begin
      if (hold_left != 0)
         hold_left <= hold_left - 1;
      else if (hold_req)
         hold_left <= HOLD_CYCLES;
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
      end
   endtask

   // Monitor: predicts on every accepted request, checks every accepted result
   always @(posedge clock) begin : monitor
      result_type want, seen;
      logic       got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            parse_tape_byte(req_tdata, req_tlast, got, want);
            if (got)
               blocks_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = result_type'({rsp_tuser, rsp_tdata});
            if (blocks_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual %h", $time, seen);
            end else begin
               want = blocks_due.pop_front();
               check_field("block_number", 32'(want.number), 32'(seen.number));
               check_field("block_kind",   32'(want.kind),   32'(seen.kind));
               check_field("block_offset", want.offset,      seen.offset);
               check_field("block_size",   want.size,        seen.size);
               check_field("status",       32'(want.status), 32'(seen.status));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tape_image_block_splitter test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_item(input logic [7:0] b, input logic last);
      tape_byte_type t;
      t.data = b;
      t.last = last;
      bytes_to_send.push_back(t);
      sent_in_phase++;
   endtask

   // sends part of the built image; ends marks the final byte sent as image end
   task automatic send_bytes(input int first, input int count, input logic ends);
      for (int i = 0; i < count; i++)
         push_item(image_bytes[first + i], ends && (i == count - 1));
   endtask

   // sampled on the falling edge, so nothing is mid-update
   task automatic wait_idle();
      do
         @(negedge clock);
      while (bytes_to_send.size() != 0 || req_tvalid || blocks_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_format(input logic tzx);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tzx;
      fmt_tzx = tzx;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // appends one block; huge picks a wide random length and sends only a few body bytes
   task automatic add_block(input logic [7:0] id, input logic tap, input logic huge);
      block_shape_type s;
      logic [31:0]  len;
      longint       body;
      int           r;
      s = shape_of(id, tap);
      r = $urandom_range(0, 9);
      if (huge)
         len = $urandom;
      else if (r < 2)
         len = 0;
      else if (r < 8)
         len = $urandom_range(1, 16);
      else
         len = $urandom_range(17, 300);
      if (s.cnt < 4)
         len = len & ((32'd1 << (8 * s.cnt)) - 32'd1);
      if (!tap)
         image_bytes.push_back(id);
      for (int h = 0; h < s.hdr; h++) begin
         if (h >= s.off && h < s.off + s.cnt)
            image_bytes.push_back(8'(len >> (8 * (h - s.off))));
         else
            image_bytes.push_back(8'($urandom));
      end
      body = longint'(len) * s.mult;
      if (huge && body > 8)
         body = 8;
      repeat (body) image_bytes.push_back(8'($urandom));
   endtask

   // random image in the current format, sometimes pure noise, sometimes cut short
   task automatic random_image();
      int         nblk, keep;
      logic [7:0] id;
      logic       huge;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 30)) image_bytes.push_back(8'($urandom));
      end else begin
         if (fmt_tzx)
            repeat (TZX_HEADER_LEN) image_bytes.push_back(8'($urandom));
         nblk = $urandom_range(1, 6);
         for (int i = 0; i < nblk; i++) begin
            huge = (i == nblk - 1) && ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 7) == 0)
               id = 8'($urandom);
            else
               id = known_ids[$urandom_range(0, 17)];
            add_block(id, !fmt_tzx, huge);
         end
      end
      if ($urandom_range(0, 99) < 65)
         keep = image_bytes.size();
      else
         keep = $urandom_range(1, image_bytes.size());
      send_bytes(0, keep, 1'b1);
      image_bytes.delete();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      clear_parser();
      fmt_tzx = 1'b1;   // register resets to TZX
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // TZX image cut inside the file header: no result at all
      image_bytes = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
      send_bytes(0, image_bytes.size(), 1'b1);
      image_bytes.delete();

      // pause block, unsupported id, zero-length text, then cut right after an id
      image_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                      ID_PAUSE, 8'hFF, 8'hFF, 8'hFF, ID_TEXT, 8'h00, ID_PULSES};
      send_bytes(0, image_bytes.size(), 1'b1);
      image_bytes.delete();

      wait_idle();
      write_format(1'b0);

      // TAP: empty block, block finishing on the last byte, then a cut in the body
      image_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};
      send_bytes(0, image_bytes.size(), 1'b1);
      image_bytes.delete();
      image_bytes = '{8'hFF, 8'hFF, 8'h80};
      send_bytes(0, image_bytes.size(), 1'b1);
      image_bytes.delete();

      // Long receiver stall while one-byte TZX blocks keep coming: the result
      // queue fills and req_tready must drop.
      wait_idle();
      write_format(1'b1);
      @(posedge clock);
      hold_req <= 1'b1;
      while (hold_left == 0) @(posedge clock);
      hold_req <= 1'b0;
      repeat (TZX_HEADER_LEN) push_item(8'($urandom), 1'b0);
      for (int i = 0; i < 40; i++)
         push_item(8'($urandom_range(0, 15)), i == 39);

      // Format change in the middle of a TZX block: the block keeps TZX,
      // the block after it is parsed as TAP.
      wait_idle();
      repeat (TZX_HEADER_LEN) image_bytes.push_back(8'($urandom));
      image_bytes.push_back(ID_STD_SPEED);
      image_bytes.push_back(8'hE8);
      image_bytes.push_back(8'h03);
      image_bytes.push_back(8'h03);   // length 3
      image_bytes.push_back(8'h00);
      repeat (3) image_bytes.push_back(8'($urandom));
      image_bytes.push_back(8'h02);   // TAP block, length 2
      image_bytes.push_back(8'h00);
      repeat (2) image_bytes.push_back(8'($urandom));
      send_bytes(0, 13, 1'b0);
      wait_idle();
      write_format(1'b0);
      send_bytes(13, image_bytes.size() - 13, 1'b1);
      image_bytes.delete();

      // Random images under three flow-control profiles
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 23; recv_idle_pct = 67; end
            1: begin send_idle_pct = 67; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         sent_in_phase = 0;
         while (sent_in_phase < PHASE_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
               wait_idle();
               write_format(1'($urandom_range(0, 1)));
            end
            random_image();
         end
      end

      wait_idle();
      if (errors == 0)
         $display("tape_image_block_splitter test passed");
      else
         $display("tape_image_block_splitter test failed");
      $finish;
   end

endmodule
